[rtl/hvup_pkg.sv]
// ----------------------------------------------------------------------------
// hvup_pkg: shared definitions for the highest voxel under point block
// Constants, register indexes and the flag group that travels from the
// classifier through the queue to the running-best tracker.
// ----------------------------------------------------------------------------
package hvup_pkg;

    // Default sizes handed to the top level parameters.
    localparam int COORD_BITS_DEF       = 16;
    localparam int NUM_SIZE_CLASSES_DEF = 10;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // Fixed field widths.
    localparam int QUERY_BITS     = 16;
    localparam int RADIUS_BITS    = 12;
    localparam int CLASS_BITS     = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SQ_BITS        = 2 * RADIUS_BITS;

    // Tops at or below this height never count.
    localparam int FLOOR_CM = -100;

    // Reset value of the radius register.
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(50);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_Z = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS  = 2'd2;

    // Classification of one item, decided in the front end.
    typedef struct packed {
        logic usable;     // carries a voxel with a legal size class
        logic last;       // closes the voxel list
        logic direct;     // footprint contains the query point
        logic far;        // clamped distance exceeds any radius on some axis
    } item_flags_t;

    localparam int FLAG_BITS = $bits(item_flags_t);

endpackage

[rtl/hvup_front.sv]
// ----------------------------------------------------------------------------
// hvup_front: configuration registers and voxel classifier
// Stage one tests footprint containment, clamps the query onto the footprint
// and forms the top height. Stage two squares the clamped distances and the
// radius. Both stages are elastic and stall only on a full queue.
// ----------------------------------------------------------------------------
module hvup_front #(
    parameter int COORD_BITS       = hvup_pkg::COORD_BITS_DEF,
    parameter int NUM_SIZE_CLASSES = hvup_pkg::NUM_SIZE_CLASSES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hvup_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [hvup_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  voxel_valid,
    input  logic signed [COORD_BITS-1:0]          voxel_x,
    input  logic signed [COORD_BITS-1:0]          voxel_y,
    input  logic signed [COORD_BITS-1:0]          voxel_z,
    input  logic [hvup_pkg::CLASS_BITS-1:0]       voxel_size_class,
    input  logic                                  last,
    output logic                                  item_valid,
    input  logic                                  item_ready,
    output hvup_pkg::item_flags_t                 item_flags,
    output logic [hvup_pkg::SQ_BITS-1:0]          item_dx2,
    output logic [hvup_pkg::SQ_BITS-1:0]          item_dz2,
    output logic [hvup_pkg::SQ_BITS-1:0]          item_r2,
    output logic signed [COORD_BITS-1:0]          item_x,
    output logic signed [COORD_BITS-1:0]          item_y,
    output logic signed [COORD_BITS-1:0]          item_z,
    output logic [hvup_pkg::CLASS_BITS-1:0]       item_class,
    output logic signed [COORD_BITS:0]            item_top
);

    import hvup_pkg::*;

    // Arithmetic width that holds query, corner, corner plus edge and their
    // differences without overflow.
    localparam int AW = ((COORD_BITS > QUERY_BITS) ? COORD_BITS : QUERY_BITS) + 2;
    localparam int TW = COORD_BITS + 1;
    localparam logic signed [AW-1:0] TOP_MAX = AW'((2 ** COORD_BITS) - 1);
    localparam logic [CLASS_BITS:0]  CLASS_LIMIT = (CLASS_BITS + 1)'(NUM_SIZE_CLASSES);

    // Configuration registers.
    logic signed [QUERY_BITS-1:0] query_x_reg;
    logic signed [QUERY_BITS-1:0] query_z_reg;
    logic [RADIUS_BITS-1:0]       radius_reg;

    // Stage one.
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    item_flags_t             s1_flags_reg;
    logic [RADIUS_BITS-1:0]  s1_adx_reg;
    logic [RADIUS_BITS-1:0]  s1_adz_reg;
    logic [RADIUS_BITS-1:0]  s1_radius_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg;
    logic signed [COORD_BITS-1:0] s1_y_reg;
    logic signed [COORD_BITS-1:0] s1_z_reg;
    logic [CLASS_BITS-1:0]   s1_class_reg;
    logic signed [TW-1:0]    s1_top_reg;

    // Stage two.
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    item_flags_t             s2_flags_reg;
    logic [SQ_BITS-1:0]      s2_dx2_reg;
    logic [SQ_BITS-1:0]      s2_dz2_reg;
    logic [SQ_BITS-1:0]      s2_r2_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg;
    logic signed [COORD_BITS-1:0] s2_y_reg;
    logic signed [COORD_BITS-1:0] s2_z_reg;
    logic [CLASS_BITS-1:0]   s2_class_reg;
    logic signed [TW-1:0]    s2_top_reg;

    logic s1_ready;
    logic s2_ready;
    logic accept;
    logic s1_move;

    // Classification results of the incoming item.
    item_flags_t            cls_flags;
    logic [RADIUS_BITS-1:0] cls_adx;
    logic [RADIUS_BITS-1:0] cls_adz;
    logic signed [TW-1:0]   cls_top;

    // Configuration writes; an index outside the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_z_reg <= '0;
            radius_reg  <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUERY_X: query_x_reg <= cfg_wdata[QUERY_BITS-1:0];
                REG_QUERY_Z: query_z_reg <= cfg_wdata[QUERY_BITS-1:0];
                REG_RADIUS:  radius_reg  <= cfg_wdata[RADIUS_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Footprint test, clamped distance and top height of the incoming voxel.
    always_comb
    begin
        logic signed [AW-1:0] vx_w;
        logic signed [AW-1:0] vy_w;
        logic signed [AW-1:0] vz_w;
        logic signed [AW-1:0] qx_w;
        logic signed [AW-1:0] qz_w;
        logic signed [AW-1:0] edge_w;
        logic signed [AW-1:0] hix_w;
        logic signed [AW-1:0] hiz_w;
        logic signed [AW-1:0] dxm;
        logic signed [AW-1:0] dzm;
        logic signed [AW-1:0] top_w;

        vx_w   = AW'(voxel_x);
        vy_w   = AW'(voxel_y);
        vz_w   = AW'(voxel_z);
        qx_w   = AW'(query_x_reg);
        qz_w   = AW'(query_z_reg);
        edge_w = AW'(1) << voxel_size_class;
        hix_w  = vx_w + edge_w - AW'(1);
        hiz_w  = vz_w + edge_w - AW'(1);

        if (qx_w < vx_w)
            dxm = vx_w - qx_w;
        else if (qx_w > hix_w)
            dxm = qx_w - hix_w;
        else
            dxm = '0;

        if (qz_w < vz_w)
            dzm = vz_w - qz_w;
        else if (qz_w > hiz_w)
            dzm = qz_w - hiz_w;
        else
            dzm = '0;

        top_w = vy_w + edge_w;
        if (top_w > TOP_MAX)
            top_w = TOP_MAX;

        cls_flags.usable = voxel_valid && ({1'b0, voxel_size_class} < CLASS_LIMIT);
        cls_flags.last   = last;
        cls_flags.direct = (vx_w <= qx_w) && (qx_w <= hix_w)
                        && (vz_w <= qz_w) && (qz_w <= hiz_w);
        cls_flags.far    = (|dxm[AW-1:RADIUS_BITS]) || (|dzm[AW-1:RADIUS_BITS]);
        cls_adx          = dxm[RADIUS_BITS-1:0];
        cls_adz          = dzm[RADIUS_BITS-1:0];
        cls_top          = top_w[TW-1:0];
    end

    // Elastic handshake between the two stages and the queue.
    assign s2_ready = !s2_valid_reg || item_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign accept   = in_valid && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
            s1_valid_next = in_valid;

        s2_valid_next = s2_valid_reg;
        if (s2_ready)
            s2_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg  <= cls_flags;
            s1_adx_reg    <= cls_adx;
            s1_adz_reg    <= cls_adz;
            s1_radius_reg <= radius_reg;
            s1_x_reg      <= voxel_x;
            s1_y_reg      <= voxel_y;
            s1_z_reg      <= voxel_z;
            s1_class_reg  <= voxel_size_class;
            s1_top_reg    <= cls_top;
        end
    end

    // Stage two payload: squared distances and squared radius.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_dx2_reg   <= SQ_BITS'(s1_adx_reg) * SQ_BITS'(s1_adx_reg);
            s2_dz2_reg   <= SQ_BITS'(s1_adz_reg) * SQ_BITS'(s1_adz_reg);
            s2_r2_reg    <= SQ_BITS'(s1_radius_reg) * SQ_BITS'(s1_radius_reg);
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_z_reg     <= s1_z_reg;
            s2_class_reg <= s1_class_reg;
            s2_top_reg   <= s1_top_reg;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item_flags = s2_flags_reg;
    assign item_dx2   = s2_dx2_reg;
    assign item_dz2   = s2_dz2_reg;
    assign item_r2    = s2_r2_reg;
    assign item_x     = s2_x_reg;
    assign item_y     = s2_y_reg;
    assign item_z     = s2_z_reg;
    assign item_class = s2_class_reg;
    assign item_top   = s2_top_reg;

endmodule

[rtl/hvup_queue.sv]
// ----------------------------------------------------------------------------
// hvup_queue: short first-in first-out queue
// Decouples the classifier from the running-best tracker so that either side
// can stall without stopping the other until the queue fills or runs empty.
// ----------------------------------------------------------------------------
module hvup_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hvup_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != COUNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= COUNT_FULL)
        else $error("queue fill count exceeds depth");

    // A lone push raises the fill count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue fill count did not follow a push");
`endif

endmodule

[rtl/hvup_back.sv]
// ----------------------------------------------------------------------------
// hvup_back: running-best tracker and result register
// Offers each classified voxel to the direct and the radius best, and on the
// item that closes a list loads the chosen best into the result register and
// starts a new list.
// ----------------------------------------------------------------------------
module hvup_back #(
    parameter int COORD_BITS = hvup_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  hvup_pkg::item_flags_t             item_flags,
    input  logic [hvup_pkg::SQ_BITS-1:0]      item_dx2,
    input  logic [hvup_pkg::SQ_BITS-1:0]      item_dz2,
    input  logic [hvup_pkg::SQ_BITS-1:0]      item_r2,
    input  logic signed [COORD_BITS-1:0]      item_x,
    input  logic signed [COORD_BITS-1:0]      item_y,
    input  logic signed [COORD_BITS-1:0]      item_z,
    input  logic [hvup_pkg::CLASS_BITS-1:0]   item_class,
    input  logic signed [COORD_BITS:0]        item_top,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic                              from_radius,
    output logic signed [COORD_BITS-1:0]      hit_x,
    output logic signed [COORD_BITS-1:0]      hit_y,
    output logic signed [COORD_BITS-1:0]      hit_z,
    output logic [hvup_pkg::CLASS_BITS-1:0]   hit_size_class,
    output logic signed [COORD_BITS:0]        top_height_cm
);

    import hvup_pkg::*;

    localparam int TW = COORD_BITS + 1;
    localparam logic signed [TW-1:0] FLOOR_TOP = TW'(FLOOR_CM);

    // Direct best.
    logic                         direct_valid_reg;
    logic signed [COORD_BITS-1:0] direct_x_reg;
    logic signed [COORD_BITS-1:0] direct_y_reg;
    logic signed [COORD_BITS-1:0] direct_z_reg;
    logic [CLASS_BITS-1:0]        direct_class_reg;
    logic signed [TW-1:0]         direct_top_reg;

    // Radius best.
    logic                         near_valid_reg;
    logic signed [COORD_BITS-1:0] near_x_reg;
    logic signed [COORD_BITS-1:0] near_y_reg;
    logic signed [COORD_BITS-1:0] near_z_reg;
    logic [CLASS_BITS-1:0]        near_class_reg;
    logic signed [TW-1:0]         near_top_reg;

    // Result register.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         found_reg;
    logic                         from_radius_reg;
    logic signed [COORD_BITS-1:0] hit_x_reg;
    logic signed [COORD_BITS-1:0] hit_y_reg;
    logic signed [COORD_BITS-1:0] hit_z_reg;
    logic [CLASS_BITS-1:0]        hit_class_reg;
    logic signed [TW-1:0]         top_reg;

    logic                 fire;
    logic [SQ_BITS:0]     dist2;
    logic                 near_hit;
    logic                 direct_take;
    logic                 near_take;
    logic                 pick_direct;
    logic                 pick_near;

    // A closing item waits only until the result register is free.
    assign item_ready = !item_flags.last || !out_valid_reg || out_ready;
    assign fire       = item_valid && item_ready;

    // Radius test and the two offers.
    assign dist2       = (SQ_BITS + 1)'(item_dx2) + (SQ_BITS + 1)'(item_dz2);
    assign near_hit    = item_flags.usable && !item_flags.far
                      && (dist2 <= (SQ_BITS + 1)'(item_r2));
    assign direct_take = item_flags.usable && item_flags.direct
                      && (item_top > direct_top_reg);
    assign near_take   = near_hit && (item_top > near_top_reg);

    // Choice made on the closing item, after its own offers.
    assign pick_direct = direct_take || direct_valid_reg;
    assign pick_near   = !pick_direct && (near_take || near_valid_reg);

    // Running bests: updated on an offer, cleared when a list closes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_valid_reg <= 1'b0;
            direct_x_reg     <= '0;
            direct_y_reg     <= '0;
            direct_z_reg     <= '0;
            direct_class_reg <= '0;
            direct_top_reg   <= FLOOR_TOP;
            near_valid_reg   <= 1'b0;
            near_x_reg       <= '0;
            near_y_reg       <= '0;
            near_z_reg       <= '0;
            near_class_reg   <= '0;
            near_top_reg     <= FLOOR_TOP;
        end
        else if (fire)
        begin
            if (item_flags.last)
            begin
                direct_valid_reg <= 1'b0;
                direct_x_reg     <= '0;
                direct_y_reg     <= '0;
                direct_z_reg     <= '0;
                direct_class_reg <= '0;
                direct_top_reg   <= FLOOR_TOP;
                near_valid_reg   <= 1'b0;
                near_x_reg       <= '0;
                near_y_reg       <= '0;
                near_z_reg       <= '0;
                near_class_reg   <= '0;
                near_top_reg     <= FLOOR_TOP;
            end
            else
            begin
                if (direct_take)
                begin
                    direct_valid_reg <= 1'b1;
                    direct_x_reg     <= item_x;
                    direct_y_reg     <= item_y;
                    direct_z_reg     <= item_z;
                    direct_class_reg <= item_class;
                    direct_top_reg   <= item_top;
                end
                if (near_take)
                begin
                    near_valid_reg <= 1'b1;
                    near_x_reg     <= item_x;
                    near_y_reg     <= item_y;
                    near_z_reg     <= item_z;
                    near_class_reg <= item_class;
                    near_top_reg   <= item_top;
                end
            end
        end
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (fire && item_flags.last)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload: direct best first, then radius best, else ground plane.
    always_ff @(posedge clk)
    begin
        if (fire && item_flags.last)
        begin
            if (pick_direct)
            begin
                found_reg       <= 1'b1;
                from_radius_reg <= 1'b0;
                hit_x_reg       <= direct_take ? item_x     : direct_x_reg;
                hit_y_reg       <= direct_take ? item_y     : direct_y_reg;
                hit_z_reg       <= direct_take ? item_z     : direct_z_reg;
                hit_class_reg   <= direct_take ? item_class : direct_class_reg;
                top_reg         <= direct_take ? item_top   : direct_top_reg;
            end
            else if (pick_near)
            begin
                found_reg       <= 1'b1;
                from_radius_reg <= 1'b1;
                hit_x_reg       <= near_take ? item_x     : near_x_reg;
                hit_y_reg       <= near_take ? item_y     : near_y_reg;
                hit_z_reg       <= near_take ? item_z     : near_z_reg;
                hit_class_reg   <= near_take ? item_class : near_class_reg;
                top_reg         <= near_take ? item_top   : near_top_reg;
            end
            else
            begin
                found_reg       <= 1'b0;
                from_radius_reg <= 1'b0;
                hit_x_reg       <= '0;
                hit_y_reg       <= '0;
                hit_z_reg       <= '0;
                hit_class_reg   <= '0;
                top_reg         <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign from_radius    = from_radius_reg;
    assign hit_x          = hit_x_reg;
    assign hit_y          = hit_y_reg;
    assign hit_z          = hit_z_reg;
    assign hit_size_class = hit_class_reg;
    assign top_height_cm  = top_reg;

`ifndef SYNTHESIS
    // A closing item leaves both bests empty for the next list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_flags.last) |=> (!direct_valid_reg && !near_valid_reg))
        else $error("bests not cleared after closing item");

    // A held best always sits above the floor height.
    assert property (@(posedge clk) disable iff (!rst_n)
        (direct_valid_reg || near_valid_reg)
            |-> ((!direct_valid_reg || direct_top_reg > FLOOR_TOP)
              && (!near_valid_reg || near_top_reg > FLOOR_TOP)))
        else $error("best held at or below floor height");

    // A ground-plane result carries a clear from_radius flag, a zero top and a zero size class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg)
            |-> (!from_radius_reg && top_reg == '0 && hit_class_reg == '0))
        else $error("ground-plane result carries nonzero fields");
`endif

endmodule

[rtl/highest_voxel_under_point.sv]
// ----------------------------------------------------------------------------
// highest_voxel_under_point: highest voxel under a query point
// Throughput: one voxel beat per cycle when the result side keeps up.
// A closing beat passes both classifier stages, a queue slot and the result
// register before its result is valid.
// Reset: asynchronous; query_x and query_z read 0, radius_cm 50, both bests
// empty with the floor as their top, pipeline and queue empty.
// ----------------------------------------------------------------------------
module highest_voxel_under_point #(
    parameter int COORD_BITS       = hvup_pkg::COORD_BITS_DEF,
    parameter int NUM_SIZE_CLASSES = hvup_pkg::NUM_SIZE_CLASSES_DEF,
    parameter int QUEUE_DEPTH      = hvup_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hvup_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [hvup_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  voxel_valid,
    input  logic signed [COORD_BITS-1:0]          voxel_x,
    input  logic signed [COORD_BITS-1:0]          voxel_y,
    input  logic signed [COORD_BITS-1:0]          voxel_z,
    input  logic [hvup_pkg::CLASS_BITS-1:0]       voxel_size_class,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  found,
    output logic                                  from_radius,
    output logic signed [COORD_BITS-1:0]          hit_x,
    output logic signed [COORD_BITS-1:0]          hit_y,
    output logic signed [COORD_BITS-1:0]          hit_z,
    output logic [hvup_pkg::CLASS_BITS-1:0]       hit_size_class,
    output logic signed [COORD_BITS:0]            top_height_cm
);

    import hvup_pkg::*;

    localparam int TW = COORD_BITS + 1;
    localparam int QW = FLAG_BITS + 3 * SQ_BITS + 3 * COORD_BITS + CLASS_BITS + TW;

    // Classifier to queue.
    logic                         f_valid;
    logic                         f_ready;
    item_flags_t                  f_flags;
    logic [SQ_BITS-1:0]           f_dx2;
    logic [SQ_BITS-1:0]           f_dz2;
    logic [SQ_BITS-1:0]           f_r2;
    logic signed [COORD_BITS-1:0] f_x;
    logic signed [COORD_BITS-1:0] f_y;
    logic signed [COORD_BITS-1:0] f_z;
    logic [CLASS_BITS-1:0]        f_class;
    logic signed [TW-1:0]         f_top;
    logic [QW-1:0]                q_push_data;

    // Queue to tracker.
    logic                         b_valid;
    logic                         b_ready;
    logic [QW-1:0]                q_pop_data;
    item_flags_t                  b_flags;
    logic [SQ_BITS-1:0]           b_dx2;
    logic [SQ_BITS-1:0]           b_dz2;
    logic [SQ_BITS-1:0]           b_r2;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic [CLASS_BITS-1:0]        b_class;
    logic signed [TW-1:0]         b_top;

    hvup_front #(
        .COORD_BITS       (COORD_BITS),
        .NUM_SIZE_CLASSES (NUM_SIZE_CLASSES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .voxel_valid      (voxel_valid),
        .voxel_x          (voxel_x),
        .voxel_y          (voxel_y),
        .voxel_z          (voxel_z),
        .voxel_size_class (voxel_size_class),
        .last             (last),
        .item_valid       (f_valid),
        .item_ready       (f_ready),
        .item_flags       (f_flags),
        .item_dx2         (f_dx2),
        .item_dz2         (f_dz2),
        .item_r2          (f_r2),
        .item_x           (f_x),
        .item_y           (f_y),
        .item_z           (f_z),
        .item_class       (f_class),
        .item_top         (f_top)
    );

    // Pack one classified item into a queue entry.
    assign q_push_data = {f_flags, f_dx2, f_dz2, f_r2, f_x, f_y, f_z, f_class, f_top};

    hvup_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_push_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_pop_data)
    );

    // Unpack the head entry.
    assign {b_flags, b_dx2, b_dz2, b_r2, b_x, b_y, b_z, b_class, b_top} = q_pop_data;

    hvup_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (b_valid),
        .item_ready     (b_ready),
        .item_flags     (b_flags),
        .item_dx2       (b_dx2),
        .item_dz2       (b_dz2),
        .item_r2        (b_r2),
        .item_x         (b_x),
        .item_y         (b_y),
        .item_z         (b_z),
        .item_class     (b_class),
        .item_top       (b_top),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .from_radius    (from_radius),
        .hit_x          (hit_x),
        .hit_y          (hit_y),
        .hit_z          (hit_z),
        .hit_size_class (hit_size_class),
        .top_height_cm  (top_height_cm)
    );

endmodule
